// File: rtl/kcd_pkg.sv
// ============================================================================
// kcd_pkg
// Shared constants, codes and controller/datapath interface types for the
// keyboard command dispatcher.
// ============================================================================
package kcd_pkg;

    localparam int LINE_DEPTH  = 64;
    localparam int TABLE_DEPTH = 256;

    localparam int CHAR_W = 8;
    localparam int ID_W   = 8;
    localparam int TAB_W  = $clog2(TABLE_DEPTH);
    localparam int ADDR_W = $clog2(LINE_DEPTH);
    // length runs 0 .. LINE_DEPTH + 1 (the top value marks an overlong line)
    localparam int LEN_W  = $clog2(LINE_DEPTH + 2);

    localparam logic [CHAR_W-1:0] KEY_CR  = 8'h0D;
    localparam logic [CHAR_W-1:0] KEY_PCT = 8'h25;

    localparam logic [LEN_W-1:0] LINE_FULL = LEN_W'(LINE_DEPTH);

    typedef enum logic [1:0] {
        KIND_NONE     = 2'd0,
        KIND_INVALID  = 2'd1,
        KIND_NOTFOUND = 2'd2,
        KIND_CHAR     = 2'd3
    } msg_kind_t;

    typedef enum logic {
        OP_KEY = 1'b0,
        OP_REG = 1'b1
    } op_t;

    // controller -> datapath
    typedef struct packed {
        logic      reg_write;     // bind command character to handler id
        logic      key_append;    // store key, bump length
        logic      emit_simple;   // load single-word result
        msg_kind_t simple_kind;
        logic      clear_line;
        logic      stream_start;
        logic      stream_emit;
    } kcd_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic key_is_cr;
        logic line_invalid;
        logic line_notfound;
        logic out_free;
        logic stream_last;
    } kcd_status_t;

endpackage

// File: rtl/kcd_ctrl.sv
// ============================================================================
// kcd_ctrl
// Controller: decodes accepted words and sequences the dispatch stream.
// ============================================================================
module kcd_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                op,
    output logic                in_ready,
    input  kcd_pkg::kcd_status_t status,
    output kcd_pkg::kcd_cmd_t    cmd
);
    import kcd_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_STREAM
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    always_comb
    begin
        cmd         = '0;
        cmd.simple_kind = KIND_NONE;
        state_next  = state_reg;
        in_ready    = 1'b0;
        accept      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = status.out_free;
                accept   = in_valid && status.out_free;
                if (accept)
                begin
                    if (op == OP_REG)
                    begin
                        cmd.reg_write = 1'b1;
                    end
                    else if (!status.key_is_cr)
                    begin
                        cmd.key_append  = 1'b1;
                        cmd.emit_simple = 1'b1;
                        cmd.simple_kind = KIND_NONE;
                    end
                    else if (status.line_invalid)
                    begin
                        cmd.emit_simple = 1'b1;
                        cmd.simple_kind = KIND_INVALID;
                        cmd.clear_line  = 1'b1;
                    end
                    else if (status.line_notfound)
                    begin
                        cmd.emit_simple = 1'b1;
                        cmd.simple_kind = KIND_NOTFOUND;
                        cmd.clear_line  = 1'b1;
                    end
                    else
                    begin
                        cmd.stream_start = 1'b1;
                        cmd.clear_line   = 1'b1;
                        state_next       = ST_STREAM;
                    end
                end
            end
            ST_STREAM:
            begin
                if (status.out_free)
                begin
                    cmd.stream_emit = 1'b1;
                    if (status.stream_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: rtl/kcd_datapath.sv
// ============================================================================
// kcd_datapath
// Line buffer, handler table, length counter and the output word register.
// ============================================================================
module kcd_datapath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [kcd_pkg::CHAR_W-1:0]      key_char,
    input  logic [kcd_pkg::ID_W-1:0]        handler_id,
    input  kcd_pkg::kcd_cmd_t               cmd,
    output kcd_pkg::kcd_status_t            status,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            echo_valid,
    output logic [kcd_pkg::CHAR_W-1:0]      echo_char,
    output logic [1:0]                      msg_kind,
    output logic [kcd_pkg::ID_W-1:0]        dest_id,
    output logic [kcd_pkg::CHAR_W-1:0]      msg_char,
    output logic                            last
);
    import kcd_pkg::*;

    // storage
    logic [CHAR_W-1:0]      line_mem [LINE_DEPTH];
    logic [ID_W-1:0]        id_mem   [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] bound_reg;

    logic [LEN_W-1:0]  len_reg;
    logic [LEN_W-1:0]  disp_len_reg;
    logic [CHAR_W-1:0] first_char_reg;
    logic [CHAR_W-1:0] second_char_reg;
    logic [ADDR_W-1:0] idx_reg;
    logic [ADDR_W-1:0] idx_next;
    logic [CHAR_W-1:0] rd_char_reg;
    logic [ID_W-1:0]   tab_id_reg;

    // output word
    logic              out_valid_reg;
    logic              echo_valid_reg;
    logic [CHAR_W-1:0] echo_char_reg;
    msg_kind_t         msg_kind_reg;
    logic [ID_W-1:0]   dest_id_reg;
    logic [CHAR_W-1:0] msg_char_reg;
    logic              last_reg;

    logic stream_last;
    logic idx_first;

    assign stream_last = ({1'b0, idx_reg} == (disp_len_reg - LEN_W'(1)));
    assign idx_first   = (idx_reg == '0);

    assign status.key_is_cr     = (key_char == KEY_CR);
    assign status.line_invalid  = (len_reg == '0) || (len_reg > LINE_FULL) ||
                                  (first_char_reg != KEY_PCT);
    assign status.line_notfound = (len_reg < LEN_W'(2)) || !bound_reg[second_char_reg];
    assign status.out_free      = !out_valid_reg || out_ready;
    assign status.stream_last   = stream_last;

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.stream_start)
        begin
            idx_next = '0;
        end
        else if (cmd.stream_emit)
        begin
            idx_next = stream_last ? '0 : idx_reg + ADDR_W'(1);
        end
    end

    // memories: one write port, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.key_append && (len_reg < LINE_FULL))
        begin
            line_mem[len_reg[ADDR_W-1:0]] <= key_char;
        end
        rd_char_reg <= line_mem[idx_next];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.reg_write)
        begin
            id_mem[key_char[TAB_W-1:0]] <= handler_id;
        end
        tab_id_reg <= id_mem[second_char_reg[TAB_W-1:0]];
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        if (cmd.stream_start)
        begin
            disp_len_reg <= len_reg;
        end
        if (cmd.key_append && (len_reg == LEN_W'(0)))
        begin
            first_char_reg <= key_char;
        end
        if (cmd.key_append && (len_reg == LEN_W'(1)))
        begin
            second_char_reg <= key_char;
        end
        if (cmd.emit_simple)
        begin
            echo_valid_reg <= 1'b1;
            echo_char_reg  <= key_char;
            msg_kind_reg   <= cmd.simple_kind;
            dest_id_reg    <= '0;
            msg_char_reg   <= '0;
            last_reg       <= 1'b1;
        end
        else if (cmd.stream_emit)
        begin
            echo_valid_reg <= idx_first;
            echo_char_reg  <= idx_first ? KEY_CR : '0;
            msg_kind_reg   <= KIND_CHAR;
            dest_id_reg    <= tab_id_reg;
            msg_char_reg   <= rd_char_reg;
            last_reg       <= stream_last;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bound_reg     <= '0;
            len_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.reg_write)
            begin
                bound_reg[key_char[TAB_W-1:0]] <= 1'b1;
            end
            if (cmd.clear_line)
            begin
                len_reg <= '0;
            end
            else if (cmd.key_append && (len_reg <= LINE_FULL))
            begin
                len_reg <= len_reg + LEN_W'(1);
            end
            if (cmd.emit_simple || cmd.stream_emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign echo_valid = echo_valid_reg;
    assign echo_char  = echo_char_reg;
    assign msg_kind   = msg_kind_reg;
    assign dest_id    = dest_id_reg;
    assign msg_char   = msg_char_reg;
    assign last       = last_reg;

endmodule

// File: rtl/keyboard_command_dispatcher.sv
// ============================================================================
// keyboard_command_dispatcher
// Echoes key words, buffers a command line and dispatches it on carriage
// return to the handler bound to its command character.
// ============================================================================
// Takes one word at a time. A handler registration (op 1) binds key_char to
// handler_id and produces no result. A key stroke produces one echo
// result, loaded into the output register in the cycle it is accepted. A
// carriage return whose line is rejected (invalid or not found) also gives
// a single result. A carriage return that dispatches streams one result
// per line character, one per cycle while the sink is ready. An N-character
// line occupies the block from the cycle that accepts the carriage return
// through its N stream results, plus any output backpressure. The line
// buffer's single registered read port sets the one-character-per-cycle
// pace. The handler table starts out fully unbound after reset with no
// clearing pass.
module keyboard_command_dispatcher (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        op,
    input  logic [kcd_pkg::CHAR_W-1:0]  key_char,
    input  logic [kcd_pkg::ID_W-1:0]    handler_id,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        echo_valid,
    output logic [kcd_pkg::CHAR_W-1:0]  echo_char,
    output logic [1:0]                  msg_kind,
    output logic [kcd_pkg::ID_W-1:0]    dest_id,
    output logic [kcd_pkg::CHAR_W-1:0]  msg_char,
    output logic                        last
);
    import kcd_pkg::*;

    kcd_cmd_t    cmd;
    kcd_status_t status;

    // Controller: accepts a word only when the output register is free or
    // being drained, and steps through the stream on carriage return.
    kcd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .op       (op),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath: line buffer, handler table with bound flags, length
    // counter (saturates at one past full to flag an overlong line) and
    // the output word register.
    kcd_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .key_char   (key_char),
        .handler_id (handler_id),
        .cmd        (cmd),
        .status     (status),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .echo_valid (echo_valid),
        .echo_char  (echo_char),
        .msg_kind   (msg_kind),
        .dest_id    (dest_id),
        .msg_char   (msg_char),
        .last       (last)
    );

endmodule
